// ----- rtl/gjmi_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// gjmi_pkg
// Shared types and constants for the Gauss-Jordan matrix inverse block.
// ---------------------------------------------------------------------------
package gjmi_pkg;

  localparam int DataW = 32;
  localparam logic signed [DataW-1:0] FracOne = 32'sh0001_0000;
  localparam logic signed [63:0] SatMax = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SatMin = -64'sh0000_0000_8000_0000;

  // datapath operation codes
  typedef enum logic [2:0] {
    OP_NONE,
    OP_IDENT,
    OP_LDPIV,
    OP_DIV,
    OP_SETONE,
    OP_LDCOEF,
    OP_ELIM
  } op_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_busy;
    logic piv_zero;
  } dp_stat_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [63:0] v);
    logic signed [DataW-1:0] r;
    if (v > SatMax) r = 32'sh7FFF_FFFF;
    else if (v < SatMin) r = 32'sh8000_0000;
    else r = v[DataW-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/gjmi_if.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// gjmi_in_if / gjmi_out_if
// Valid/ready channels for matrix elements in and inverse elements out.
// ---------------------------------------------------------------------------
interface gjmi_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] element_value;
  logic last_element;
  modport source (output valid, output element_value, output last_element, input ready);
  modport sink (input valid, input element_value, input last_element, output ready);
endinterface

interface gjmi_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] inverse_value;
  logic singular;
  logic last_result;
  modport source (output valid, output inverse_value, output singular, output last_result,
                  input ready);
  modport sink (input valid, input inverse_value, input singular, input last_result,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/gjmi_div.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// gjmi_div
// Restoring divider, one quotient bit per cycle: (a * 2^16) / p, truncated
// toward zero and saturated to 32 bits.
// ---------------------------------------------------------------------------
module gjmi_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] dividend,
  input  wire logic signed [31:0] divisor,
  output logic                    busy,
  output logic                    done,
  output logic signed [31:0]      quotient
);
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [47:0] num_r, num_nxt;
  logic [47:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic        neg_r, neg_nxt;
  logic [48:0] trial;
  logic [47:0] shifted;
  logic signed [49:0] sq;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    shifted  = {rem_r[46:0], num_r[47]};
    trial    = {1'b0, shifted} - {17'd0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd0;
      num_nxt  = {(dividend[31] ? 32'(-dividend) : 32'(dividend)), 16'd0};
      rem_nxt  = '0;
      den_nxt  = divisor[31] ? 32'(-divisor) : 32'(divisor);
      neg_nxt  = dividend[31] ^ divisor[31];
    end else if (busy_r) begin
      num_nxt = {num_r[46:0], ~trial[48]};
      rem_nxt = trial[48] ? shifted : trial[47:0];
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd47) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign sq = neg_r ? -$signed({2'b00, num_r}) : $signed({2'b00, num_r});
  assign quotient = gjmi_pkg::sat32(64'(sq));
  assign busy = busy_r;
  assign done = done_r;
endmodule
`default_nettype wire

// ----- rtl/gjmi_datapath.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// gjmi_datapath
// Augmented matrix store, load port, shared multiply-subtract and divider.
// ---------------------------------------------------------------------------
module gjmi_datapath #(
  parameter int MAX_DIM = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          clr,
  input  wire logic                          ld_we,
  input  wire logic [$clog2(MAX_DIM)-1:0]    ld_row,
  input  wire logic [$clog2(MAX_DIM)-1:0]    ld_col,
  input  wire logic signed [31:0]            ld_data,
  input  gjmi_pkg::op_t                      op,
  input  wire logic [$clog2(MAX_DIM)-1:0]    piv,
  input  wire logic [$clog2(MAX_DIM)-1:0]    row,
  input  wire logic [$clog2(2*MAX_DIM)-1:0]  col,
  input  wire logic [$clog2(MAX_DIM)-1:0]    rd_row,
  input  wire logic [$clog2(2*MAX_DIM)-1:0]  rd_col,
  output logic signed [31:0]                 rd_data,
  output gjmi_pkg::dp_stat_t                 stat
);
  localparam int RW = $clog2(MAX_DIM);
  localparam int CW = $clog2(2*MAX_DIM);

  logic signed [31:0] mat_r [MAX_DIM][2*MAX_DIM];
  logic signed [31:0] pv_r;
  logic signed [31:0] coef_r;
  logic signed [63:0] prod;
  logic signed [63:0] rnd;
  logic signed [63:0] diff;
  logic               div_busy, div_done;
  logic signed [31:0] div_q;
  logic [RW-1:0]      dw_row_r;
  logic [CW-1:0]      dw_col_r;

  // fx multiply: floor((a*b + 2^15) / 2^16)
  assign prod = 64'(mat_r[piv][col]) * 64'(coef_r) + 64'sd32768;
  assign rnd  = prod >>> 16;
  assign diff = 64'(mat_r[row][col]) - rnd;

  gjmi_div u_div (
    .clk(clk), .rst_n(rst_n),
    .start(op == gjmi_pkg::OP_DIV),
    .dividend(mat_r[piv][col]),
    .divisor(pv_r),
    .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (clr) begin
      // first beat of a matrix lands in the freshly cleared store
      for (int r = 0; r < MAX_DIM; r++)
        for (int c = 0; c < 2*MAX_DIM; c++)
          mat_r[r][c] <= (ld_we && RW'(r) == ld_row && CW'(c) == CW'(ld_col)) ?
                         ld_data : '0;
    end else if (ld_we) begin
      mat_r[ld_row][CW'(ld_col)] <= ld_data;
    end else begin
      case (op)
        gjmi_pkg::OP_IDENT:  mat_r[row][col] <= gjmi_pkg::FracOne;
        gjmi_pkg::OP_LDPIV:  pv_r <= mat_r[piv][col];
        gjmi_pkg::OP_DIV: begin
          dw_row_r <= piv;
          dw_col_r <= col;
        end
        gjmi_pkg::OP_SETONE: mat_r[piv][col] <= gjmi_pkg::FracOne;
        gjmi_pkg::OP_LDCOEF: coef_r <= mat_r[row][col];
        gjmi_pkg::OP_ELIM:   mat_r[row][col] <= gjmi_pkg::sat32(diff);
        default: ;
      endcase
      if (div_done) mat_r[dw_row_r][dw_col_r] <= div_q;
    end
    rd_data <= mat_r[rd_row][rd_col];
  end

  assign stat.div_busy = div_busy | (op == gjmi_pkg::OP_DIV) | div_done;
  assign stat.piv_zero = (mat_r[piv][col] == '0);
endmodule
`default_nettype wire

// ----- rtl/gjmi_ctrl.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// gjmi_ctrl
// Sequencer: load, identity, forward and backward passes, result output.
// ---------------------------------------------------------------------------
module gjmi_ctrl #(
  parameter int MAX_DIM = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [2:0]                    cfg_size,
  gjmi_in_if.sink                            in_ch,
  gjmi_out_if.source                         out_ch,
  output logic                               clr,
  output logic                               ld_we,
  output logic [$clog2(MAX_DIM)-1:0]         ld_row,
  output logic [$clog2(MAX_DIM)-1:0]         ld_col,
  output gjmi_pkg::op_t                      op,
  output logic [$clog2(MAX_DIM)-1:0]         piv,
  output logic [$clog2(MAX_DIM)-1:0]         row,
  output logic [$clog2(2*MAX_DIM)-1:0]       col,
  output logic [$clog2(MAX_DIM)-1:0]         rd_row,
  output logic [$clog2(2*MAX_DIM)-1:0]       rd_col,
  input  wire logic signed [31:0]            rd_data,
  input  gjmi_pkg::dp_stat_t                 stat
);
  localparam int RW = $clog2(MAX_DIM);
  localparam int CW = $clog2(2*MAX_DIM);
  localparam int NW = $clog2(MAX_DIM+1);
  localparam int LW = $clog2(MAX_DIM*MAX_DIM+1);

  typedef enum logic [3:0] {
    S_LOAD, S_IDENT, S_FPIV, S_FDIV, S_FWAIT, S_FONE, S_COEF, S_ELIM,
    S_EMIT_RD, S_EMIT
  } state_t;

  state_t        state_r;
  logic [NW-1:0] n_r;
  logic [LW-1:0] cnt_r;
  logic [RW-1:0] piv_r, row_r;
  logic [CW-1:0] col_r;
  logic          bwd_r, sing_r, rd_pend_r;
  logic [NW-1:0] neff;
  logic [RW-1:0] lrow, lcol;
  logic          in_fire;

  always_comb begin
    if (cfg_size == 3'd0) neff = NW'(1);
    else if (32'(cfg_size) > MAX_DIM) neff = NW'(MAX_DIM);
    else neff = NW'(cfg_size);
  end

  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_LOAD);
  assign clr = in_fire && (cnt_r == '0);
  assign ld_we = in_fire && (32'(cnt_r) < 32'(neff) * 32'(neff));
  assign ld_row = lrow;
  assign ld_col = lcol;

  // row/column of the load position from the count under the size in force
  always_comb begin
    lrow = '0;
    lcol = '0;
    for (int r = 0; r < MAX_DIM; r++)
      for (int c = 0; c < MAX_DIM; c++)
        if (32'(c) < 32'(neff) && 32'(cnt_r) == 32'(r) * 32'(neff) + 32'(c)) begin
          lrow = RW'(r);
          lcol = RW'(c);
        end
  end

  assign piv = piv_r;
  assign row = row_r;
  assign col = col_r;

  always_comb begin
    op = gjmi_pkg::OP_NONE;
    case (state_r)
      S_IDENT: op = gjmi_pkg::OP_IDENT;
      S_FPIV:  op = stat.piv_zero ? gjmi_pkg::OP_NONE : gjmi_pkg::OP_LDPIV;
      S_FDIV:  op = (col_r == CW'(piv_r)) ? gjmi_pkg::OP_NONE : gjmi_pkg::OP_DIV;
      S_FONE:  op = gjmi_pkg::OP_SETONE;
      S_COEF:  op = gjmi_pkg::OP_LDCOEF;
      S_ELIM:  op = gjmi_pkg::OP_ELIM;
      default: op = gjmi_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      cnt_r     <= '0;
      n_r       <= NW'(1);
      piv_r     <= '0;
      row_r     <= '0;
      col_r     <= '0;
      bwd_r     <= 1'b0;
      sing_r    <= 1'b0;
      rd_pend_r <= 1'b0;
      rd_row    <= '0;
      rd_col    <= '0;
      out_ch.valid <= 1'b0;
      out_ch.last_result <= 1'b0;
      out_ch.singular <= 1'b0;
      out_ch.inverse_value <= '0;
    end else begin
      case (state_r)
        S_LOAD: begin
          if (in_fire) begin
            if (ld_we) cnt_r <= cnt_r + LW'(1);
            if (in_ch.last_element) begin
              n_r   <= neff;
              state_r <= S_IDENT;
              row_r <= '0;
              col_r <= CW'(neff);
              sing_r <= 1'b0;
            end
          end
        end
        S_IDENT: begin
          if (NW'(row_r) + NW'(1) >= n_r) begin
            state_r <= S_FPIV;
            piv_r <= '0;
            col_r <= '0;
            bwd_r <= 1'b0;
          end else begin
            row_r <= row_r + RW'(1);
            col_r <= col_r + CW'(1);
          end
        end
        S_FPIV: begin
          if (stat.piv_zero) begin
            sing_r <= 1'b1;
            state_r <= S_EMIT_RD;
            rd_row <= '0;
            rd_col <= CW'(n_r);
            row_r <= '0;
            col_r <= '0;
          end else begin
            state_r <= S_FDIV;
            col_r <= '0;
          end
        end
        S_FDIV: begin
          if (col_r != CW'(piv_r)) state_r <= S_FWAIT;
          else if (32'(col_r) + 1 >= 2*32'(n_r)) begin
            state_r <= S_FONE;
            col_r <= CW'(piv_r);
          end else col_r <= col_r + CW'(1);
        end
        S_FWAIT: begin
          if (!stat.div_busy) begin
            if (32'(col_r) + 1 >= 2*32'(n_r)) begin
              state_r <= S_FONE;
              col_r <= CW'(piv_r);
            end else begin
              col_r <= col_r + CW'(1);
              state_r <= S_FDIV;
            end
          end
        end
        S_FONE: begin
          if (NW'(piv_r) + NW'(1) >= n_r) begin
            // forward done: backward pass from last pivot, or straight to output when n is 1
            if (piv_r == '0) begin
              state_r <= S_EMIT_RD;
              rd_row <= '0;
              rd_col <= CW'(n_r);
              row_r <= '0;
              col_r <= '0;
            end else begin
              bwd_r <= 1'b1;
              row_r <= '0;
              col_r <= CW'(piv_r);
              state_r <= S_COEF;
            end
          end else begin
            row_r <= piv_r + RW'(1);
            col_r <= CW'(piv_r);
            state_r <= S_COEF;
          end
        end
        S_COEF: begin
          col_r <= '0;
          state_r <= S_ELIM;
        end
        S_ELIM: begin
          if (32'(col_r) + 1 < 2*32'(n_r)) col_r <= col_r + CW'(1);
          else if (!bwd_r) begin
            if (NW'(row_r) + NW'(1) < n_r) begin
              row_r <= row_r + RW'(1);
              col_r <= CW'(piv_r);
              state_r <= S_COEF;
            end else begin
              piv_r <= piv_r + RW'(1);
              state_r <= S_FPIV;
              col_r <= CW'(piv_r + RW'(1));
            end
          end else begin
            if (row_r + RW'(1) < piv_r) begin
              row_r <= row_r + RW'(1);
              col_r <= CW'(piv_r);
              state_r <= S_COEF;
            end else if (piv_r == RW'(1)) begin
              state_r <= S_EMIT_RD;
              rd_row <= '0;
              rd_col <= CW'(n_r);
              row_r <= '0;
              col_r <= '0;
            end else begin
              piv_r <= piv_r - RW'(1);
              row_r <= '0;
              col_r <= CW'(piv_r - RW'(1));
              state_r <= S_COEF;
            end
          end
        end
        S_EMIT_RD: begin
          // read data is registered and lands the cycle after its address
          if (rd_pend_r && (!out_ch.valid || out_ch.ready)) begin
            rd_pend_r <= 1'b0;
            out_ch.valid <= 1'b1;
            out_ch.inverse_value <= sing_r ? '0 : rd_data;
            out_ch.singular <= sing_r;
            out_ch.last_result <= (NW'(row_r) + NW'(1) >= n_r) &&
                                  (NW'(col_r) + NW'(1) >= n_r);
            state_r <= S_EMIT;
          end else begin
            rd_pend_r <= 1'b1;
            if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
          end
        end
        S_EMIT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            if (out_ch.last_result) begin
              state_r <= S_LOAD;
              cnt_r <= '0;
            end else begin
              if (NW'(col_r) + NW'(1) >= n_r) begin
                col_r <= '0;
                row_r <= row_r + RW'(1);
                rd_row <= row_r + RW'(1);
                rd_col <= CW'(n_r);
              end else begin
                col_r <= col_r + CW'(1);
                rd_col <= rd_col + CW'(1);
              end
              state_r <= S_EMIT_RD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  a_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> !in_ch.ready) else $error("ready outside load");
  a_out_zero_sing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.singular) |-> (out_ch.inverse_value == '0))
    else $error("singular result not zero");
  a_last_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last_result) |=> (state_r == S_LOAD))
    else $error("no return to load");
endmodule
`default_nettype wire

// ----- rtl/gauss_jordan_matrix_inverse_top.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// gauss_jordan_matrix_inverse_top
// Matrix inverse by Gauss-Jordan elimination, no pivoting, Q16.16.
//
// channel | dir | payload
// in_     | in  | element_value, last_element
// out_    | out | inverse_value, singular, last_result
// cfg_    | in  | matrix_size (write only)
//
// one element a cycle on load; inversion then runs each divide on the serial
// divider (one bit a cycle) and each row elimination on the shared
// multiplier; results go out one at a time, each read from the store first.
// input is held off from the last element until the final result beat.
// synchronous active-low reset; the store clears on the first element.
// ---------------------------------------------------------------------------
module gauss_jordan_matrix_inverse_top #(
  parameter int MAX_DIM = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_wdata,
  gjmi_in_if.sink         in_ch,
  gjmi_out_if.source      out_ch
);
  logic [2:0]                   size_r;
  logic                         clr, ld_we;
  logic [$clog2(MAX_DIM)-1:0]   ld_row, ld_col, piv, row, rd_row;
  logic [$clog2(2*MAX_DIM)-1:0] col, rd_col;
  gjmi_pkg::op_t                op;
  gjmi_pkg::dp_stat_t           stat;
  logic signed [31:0]           rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) size_r <= 3'd4;
    else if (cfg_we) size_r <= cfg_wdata;
  end

  gjmi_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .cfg_size(size_r), .in_ch(in_ch), .out_ch(out_ch),
    .clr(clr), .ld_we(ld_we), .ld_row(ld_row), .ld_col(ld_col), .op(op),
    .piv(piv), .row(row), .col(col), .rd_row(rd_row), .rd_col(rd_col),
    .rd_data(rd_data), .stat(stat)
  );

  gjmi_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk(clk), .rst_n(rst_n), .clr(clr), .ld_we(ld_we), .ld_row(ld_row),
    .ld_col(ld_col), .ld_data(in_ch.element_value), .op(op), .piv(piv),
    .row(row), .col(col), .rd_row(rd_row), .rd_col(rd_col),
    .rd_data(rd_data), .stat(stat)
  );
endmodule
`default_nettype wire

// ----- tb/sv/gjmi_inverse_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gjmi_inverse_checker
// Watches the element and inverse channels, computes each expected inverse
// with a Q16.16 Gauss-Jordan predictor and compares every result beat.
// ---------------------------------------------------------------------------
module gjmi_inverse_checker #(
  parameter int MAX_DIM = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_wdata,
  gjmi_in_if              in_ch,
  gjmi_out_if             out_ch,
  output int              fail_count,
  output int              pending_count
);

  typedef struct packed {
    logic signed [31:0] value;
    logic               singular;
    logic               last;
  } inv_beat_t;

  inv_beat_t              inverse_q[$];
  logic [2:0]             size_reg;
  logic signed [31:0]     aug [MAX_DIM][2*MAX_DIM];
  int unsigned            loaded;

  function automatic logic signed [31:0] sat_q(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // round half up: floor((a*b + 2^15) / 2^16)
  function automatic logic signed [63:0] q_mul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd32768;
    return p >>> 16;
  endfunction

  function automatic logic signed [31:0] q_div(input logic signed [31:0] a,
                                               input logic signed [31:0] p);
    logic signed [63:0] num;
    num = 64'(a) * 64'sd65536;
    return sat_q(num / 64'(p));
  endfunction

  function automatic int dim_in_use();
    int n;
    n = size_reg;
    if (n < 1) n = 1;
    if (n > MAX_DIM) n = MAX_DIM;
    return n;
  endfunction

  task automatic eliminate_row(input int r, input int y, input int n);
    logic signed [31:0] c;
    c = aug[r][y];
    for (int j = 0; j < 2 * n; j++)
      aug[r][j] = sat_q(64'(aug[r][j]) - q_mul(aug[y][j], c));
  endtask

  task automatic predict_inverse(input int n);
    logic               sing;
    logic signed [31:0] p;
    inv_beat_t          b;
    sing = 1'b0;
    for (int y = 0; y < n; y++) aug[y][n + y] = 32'sh0001_0000;
    for (int y = 0; y < n && !sing; y++) begin
      p = aug[y][y];
      if (p == 0) begin
        sing = 1'b1;
      end else begin
        for (int x = 0; x < 2 * n; x++)
          if (x != y) aug[y][x] = q_div(aug[y][x], p);
        aug[y][y] = 32'sh0001_0000;
        for (int r = y + 1; r < n; r++) eliminate_row(r, y, n);
      end
    end
    if (!sing)
      for (int y = n - 1; y > 0; y--)
        for (int r = 0; r < y; r++) eliminate_row(r, y, n);
    for (int k = 0; k < n * n; k++) begin
      b.value    = sing ? 32'sd0 : aug[k / n][n + k % n];
      b.singular = sing;
      b.last     = (k == n * n - 1);
      inverse_q.push_back(b);
    end
  endtask

  always @(posedge clk) begin
    int        n;
    inv_beat_t want;
    if (!rst_n) begin
      size_reg   <= 3'd4;
      loaded     = 0;
      fail_count <= 0;
      for (int r = 0; r < MAX_DIM; r++)
        for (int c = 0; c < 2 * MAX_DIM; c++) aug[r][c] = '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        n = dim_in_use();
        if (loaded == 0)
          for (int r = 0; r < MAX_DIM; r++)
            for (int c = 0; c < 2 * MAX_DIM; c++) aug[r][c] = '0;
        if (loaded < n * n) begin
          aug[loaded / n][loaded % n] = in_ch.element_value;
          loaded++;
        end
        if (in_ch.last_element) begin
          predict_inverse(n);
          loaded = 0;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (inverse_q.size() == 0) begin
          if (fail_count < 10)
            $display("mismatch: unexpected beat value=%h sing=%b last=%b",
                     out_ch.inverse_value, out_ch.singular, out_ch.last_result);
          fail_count <= fail_count + 1;
        end else begin
          want = inverse_q.pop_front();
          if (want.value !== out_ch.inverse_value || want.singular !== out_ch.singular
              || want.last !== out_ch.last_result) begin
            if (fail_count < 10)
              $display("mismatch: expected %h/%b/%b actual %h/%b/%b", want.value,
                       want.singular, want.last, out_ch.inverse_value,
                       out_ch.singular, out_ch.last_result);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_we) size_reg <= cfg_wdata;
    end
    pending_count = inverse_q.size();
  end

endmodule

// ----- tb/sv/gauss_jordan_matrix_inverse_top_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gauss_jordan_matrix_inverse_top_tb
// Drives directed matrices and matrices of random size through the inverse block under several
// idle and stall phases; a checker predicts and compares the results.
// ---------------------------------------------------------------------------
module gauss_jordan_matrix_inverse_top_tb;

  localparam int MaxDim = 4;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_wdata = 3'd4;
  int         fail_count;
  int         pending_count;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  bit         hold_off = 1'b0;
  int         size_now = 4;

  gjmi_in_if  in_ch ();
  gjmi_out_if out_ch ();

  always #5 clk = ~clk;

  gauss_jordan_matrix_inverse_top #(.MAX_DIM(MaxDim)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  gjmi_inverse_checker #(.MAX_DIM(MaxDim)) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.element_value = '0;
    in_ch.last_element = 1'b0;
    out_ch.ready = 1'b0;
  end

  // receiver stalls at random, or holds off entirely
  always @(negedge clk)
    out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

  task automatic send_beat(input logic signed [31:0] v, input logic lst);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.element_value <= v;
    in_ch.last_element <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_size(input logic [2:0] s);
    cfg_we <= 1'b1;
    cfg_wdata <= s;
    @(negedge clk);
    cfg_we <= 1'b0;
    size_now = (s == 0) ? 1 : (s > MaxDim) ? MaxDim : s;
  endtask

  function automatic logic signed [31:0] rand_elem(input int kind);
    case (kind)
      0: return $urandom();
      1: return $signed($urandom_range(262143)) - 32'sd131072;
      default: return $signed($urandom_range(65535)) - 32'sd32768;
    endcase
  endfunction

  // kind 3: well-conditioned matrix: strong diagonal, small off-diagonal terms; other kinds are random
  task automatic send_matrix(input int kind);
    int n;
    n = size_now;
    for (int k = 0; k < n * n; k++) begin
      if (kind == 3 && k / n == k % n)
        send_beat(($urandom_range(1) ? 1 : -1) * $signed(32'($urandom_range(0, 196608)
                  + 65536)), k == n * n - 1);
      else
        send_beat(kind == 3 ? rand_elem(2) : rand_elem(kind), k == n * n - 1);
    end
  endtask

  initial begin
    int phase_idle [4] = '{0, 83, 0, 13};
    int phase_stall[4] = '{0, 0, 83, 13};
    int r;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: identity, scaled, zero pivot, extremes, short and long loads
    for (int k = 0; k < 16; k++) send_beat((k % 5 == 0) ? 32'sh0001_0000 : 32'sd0, k == 15);
    wait_drained();
    write_size(3'd2);
    send_beat(32'sh7FFF_FFFF, 1'b0); send_beat(32'sh8000_0000, 1'b0);
    send_beat(32'sh0000_0001, 1'b0); send_beat(32'sh8000_0000, 1'b1);
    send_beat(32'sd0, 1'b0); send_beat(32'sh0001_0000, 1'b1);
    send_beat(32'sh0002_0000, 1'b1);
    send_beat(32'sh0001_0000, 1'b0); send_beat(32'sd5, 1'b0); send_beat(32'sd7, 1'b0);
    send_beat(32'sh0003_0000, 1'b0); send_beat(32'sh1234_5678, 1'b0);
    send_beat(32'shFFFF_FFFF, 1'b1);
    wait_drained();
    write_size(3'd0);
    send_beat(32'sh0000_8000, 1'b1); send_beat(32'sd0, 1'b1);
    wait_drained();
    write_size(3'd7);
    send_matrix(3);
    wait_drained();
    // random phases with size changes between them
    for (int ph = 0; ph < 8; ph++) begin
      send_idle_pct = phase_idle[ph % 4];
      recv_stall_pct = phase_stall[ph % 4];
      write_size(3'($urandom_range(7)));
      for (int m = 0; m < 5; m++) begin
        r = $urandom_range(9);
        if (r < 7) send_matrix(3);
        else if (r == 7) send_matrix($urandom_range(2));
        else begin
          // broken load: last marker may come early
          for (int k = $urandom_range(size_now * size_now - 1); k > 0; k--)
            send_beat(rand_elem(1), 1'b0);
          send_beat(rand_elem(2), 1'b1);
        end
      end
      if (ph == 1) begin
        // long hold-off while the sender keeps offering
        hold_off = 1'b1;
        fork
          begin
            repeat (600) @(negedge clk);
            hold_off = 1'b0;
          end
          begin
            send_matrix(3);
            send_matrix(3);
          end
        join
      end
      wait_drained();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
